/* sv/swbsf_pkg.sv */
// shared types and constants for the stop-and-wait byte-stuffing framer
package swbsf_pkg;

    // operation codes on the input tuser
    localparam logic [1:0] OP_PAYLOAD  = 2'd0;
    localparam logic [1:0] OP_END      = 2'd1;
    localparam logic [1:0] OP_RESPONSE = 2'd2;

    // response kinds on the output tuser
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_FLAG      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ESCAPE    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ADDRESS   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CTRL_ZERO = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CTRL_ONE  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_RDY_ZERO  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_RDY_ONE   = 3'd6;

    // fixed codes
    localparam logic [7:0] REJECT_CODE_ZERO = 8'd1;
    localparam logic [7:0] REJECT_CODE_ONE  = 8'd129;
    localparam logic [7:0] STUFF_FLAG       = 8'h5e;
    localparam logic [7:0] STUFF_ESC        = 8'h5d;

    // job queue geometry
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;

    // configuration register bank
    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] escape;
        logic [7:0] address;
        logic [7:0] ctrl_zero;
        logic [7:0] ctrl_one;
        logic [7:0] rdy_zero;
        logic [7:0] rdy_one;
    } t_cfg;

    // one classified item waiting for the back end
    typedef struct packed {
        logic       hdr;     // emit header first
        logic       resp;    // response report only
        logic       stuff;   // body byte goes through stuffing
        logic       close;   // append closing flag
        logic [1:0] kind;    // response kind
        logic [7:0] ctrl;    // control byte for the header
        logic [7:0] data;    // body byte
    } t_job;

endpackage

/* sv/swbsf_front.sv */
// front end: accepts items, keeps the framing state and builds jobs
module swbsf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  swbsf_pkg::t_cfg i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_op,
    input  logic [7:0]      i_data,
    output logic            o_push,
    output swbsf_pkg::t_job o_job,
    input  logic            i_q_full
);

    logic       r_seq;
    logic       n_seq;
    logic       r_hdr_sent;
    logic       n_hdr_sent;
    logic [7:0] r_acc;
    logic [7:0] n_acc;
    logic       w_take;

    assign o_ready = !i_q_full;
    assign w_take  = i_valid && !i_q_full;

    // classify the item and work out the next framing state
    always_comb begin
        n_seq        = r_seq;
        n_hdr_sent   = r_hdr_sent;
        n_acc        = r_acc;
        o_push       = 1'b0;
        o_job.hdr    = !r_hdr_sent;
        o_job.resp   = 1'b0;
        o_job.stuff  = 1'b1;
        o_job.close  = 1'b0;
        o_job.kind   = swbsf_pkg::KIND_NONE;
        o_job.ctrl   = r_seq ? i_cfg.ctrl_one : i_cfg.ctrl_zero;
        o_job.data   = i_data;
        unique case (i_op)
            swbsf_pkg::OP_PAYLOAD: begin
                o_push     = w_take;
                n_hdr_sent = 1'b1;
                n_acc      = r_acc ^ i_data;
            end
            swbsf_pkg::OP_END: begin
                o_push      = w_take;
                o_job.data  = r_acc;
                o_job.stuff = r_hdr_sent;
                o_job.close = 1'b1;
                n_hdr_sent  = 1'b0;
                n_acc       = 8'd0;
            end
            swbsf_pkg::OP_RESPONSE: begin
                o_push     = w_take;
                o_job.hdr  = 1'b0;
                o_job.resp = 1'b1;
                if ((i_data == i_cfg.rdy_one && !r_seq) ||
                    (i_data == i_cfg.rdy_zero && r_seq)) begin
                    o_job.kind = swbsf_pkg::KIND_ACK;
                    n_seq      = !r_seq;
                end else if (i_data == swbsf_pkg::REJECT_CODE_ONE ||
                             i_data == swbsf_pkg::REJECT_CODE_ZERO) begin
                    o_job.kind = swbsf_pkg::KIND_REJECT;
                end else begin
                    o_job.kind = swbsf_pkg::KIND_IGNORE;
                end
            end
            default: begin
                // unused code: dropped without effect
                o_push = 1'b0;
            end
        endcase
    end

    // framing state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= 1'b0;
            r_hdr_sent <= 1'b0;
            r_acc      <= 8'd0;
        end else if (w_take) begin
            r_seq      <= n_seq;
            r_hdr_sent <= n_hdr_sent;
            r_acc      <= n_acc;
        end
    end

endmodule

/* sv/swbsf_queue.sv */
// short job queue between the front end and the back end
module swbsf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swbsf_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output swbsf_pkg::t_job o_job
);

    swbsf_pkg::t_job                   r_mem [swbsf_pkg::Q_DEPTH];
    logic [swbsf_pkg::Q_AW-1:0]        r_wptr;
    logic [swbsf_pkg::Q_AW-1:0]        r_rptr;
    logic [swbsf_pkg::Q_AW:0]          r_count;
    logic                              w_pop;

    assign o_full  = (r_count == (swbsf_pkg::Q_AW+1)'(swbsf_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/swbsf_back.sv */
// back end: expands each job into line bytes, one per cycle unless the output stalls
module swbsf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  swbsf_pkg::t_cfg i_cfg,
    input  logic            i_job_valid,
    input  swbsf_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic [3:0]      o_user,
    output logic            o_last
);

    // step codes within one job
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_HDR0  = 3'd1;
    localparam logic [2:0] PH_HDR1  = 3'd2;
    localparam logic [2:0] PH_HDR2  = 3'd3;
    localparam logic [2:0] PH_HDR3  = 3'd4;
    localparam logic [2:0] PH_BODY  = 3'd5;
    localparam logic [2:0] PH_SUB   = 3'd6;
    localparam logic [2:0] PH_CLOSE = 3'd7;

    logic [2:0] r_phase;
    logic [2:0] w_phase;
    logic [2:0] n_phase;
    logic       w_done;
    logic       w_load;
    logic [7:0] w_byte;
    logic       w_bvalid;
    logic       w_fend;
    logic [1:0] w_kind;
    logic       w_is_flag;
    logic       w_is_esc;

    logic       r_valid;
    logic [7:0] r_byte;
    logic [3:0] r_user;
    logic       r_last;

    assign w_is_flag = (i_job.data == i_cfg.flag);
    assign w_is_esc  = (i_job.data == i_cfg.escape);
    assign w_phase   = (r_phase != PH_START) ? r_phase :
                       (i_job.hdr ? PH_HDR0 : PH_BODY);
    assign w_load    = i_job_valid && (!r_valid || i_ready);
    assign o_pop     = w_load && w_done;

    // current byte and the step after it
    always_comb begin
        w_byte   = 8'd0;
        w_bvalid = 1'b1;
        w_fend   = 1'b0;
        w_kind   = swbsf_pkg::KIND_NONE;
        w_done   = 1'b0;
        n_phase  = PH_START;
        unique case (w_phase)
            PH_HDR0: begin
                w_byte  = i_cfg.flag;
                n_phase = PH_HDR1;
            end
            PH_HDR1: begin
                w_byte  = i_cfg.address;
                n_phase = PH_HDR2;
            end
            PH_HDR2: begin
                w_byte  = i_job.ctrl;
                n_phase = PH_HDR3;
            end
            PH_HDR3: begin
                w_byte  = i_cfg.address ^ i_job.ctrl;
                n_phase = PH_BODY;
            end
            PH_BODY: begin
                if (i_job.resp) begin
                    w_bvalid = 1'b0;
                    w_kind   = i_job.kind;
                    w_done   = 1'b1;
                end else if (i_job.stuff && (w_is_flag || w_is_esc)) begin
                    w_byte  = i_cfg.escape;
                    n_phase = PH_SUB;
                end else begin
                    w_byte  = i_job.data;
                    w_done  = !i_job.close;
                    n_phase = PH_CLOSE;
                end
            end
            PH_SUB: begin
                w_byte  = w_is_flag ? swbsf_pkg::STUFF_FLAG : swbsf_pkg::STUFF_ESC;
                w_done  = !i_job.close;
                n_phase = PH_CLOSE;
            end
            PH_CLOSE: begin
                w_byte = i_cfg.flag;
                w_fend = 1'b1;
                w_done = 1'b1;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    // step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
        end else if (w_load) begin
            r_phase <= w_done ? PH_START : n_phase;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_user <= {w_kind, w_fend, w_bvalid};
            r_last <= w_done;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

/* sv/stop_wait_byte_stuff_framer.sv */
// top level: configuration bank, front end, job queue and back end
// an input item is taken every cycle while the four-entry job queue has room
// a taken item is registered in the job queue, its first byte then in the output register
// the back end emits one result byte per cycle unless the output stalls: a response
// gives one report item, a payload byte 1 or 2 bytes, plus 4 with a header, an end 2 to 6
// reset (synchronous, active low) clears framing state and queue, reloads register defaults
module stop_wait_byte_stuff_framer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // data_byte
    input  logic [1:0]                  i_s_axis_tuser,  // operation
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,  // out_byte
    // response_kind[1:0], frame_end, byte_valid (msb first)
    output logic [3:0]                  o_m_axis_tuser,
    output logic                        o_m_axis_tlast,  // run_last
    input  logic                        i_cfg_we,
    input  logic [swbsf_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [7:0]                  i_cfg_wdata
);

    swbsf_pkg::t_cfg r_cfg;
    swbsf_pkg::t_job w_push_job;
    swbsf_pkg::t_job w_head_job;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_head_valid;

    // configuration register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag      <= 8'h7e;
            r_cfg.escape    <= 8'h7d;
            r_cfg.address   <= 8'h03;
            r_cfg.ctrl_zero <= 8'h00;
            r_cfg.ctrl_one  <= 8'h40;
            r_cfg.rdy_zero  <= 8'h05;
            r_cfg.rdy_one   <= 8'h85;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swbsf_pkg::REG_FLAG:      r_cfg.flag      <= i_cfg_wdata;
                swbsf_pkg::REG_ESCAPE:    r_cfg.escape    <= i_cfg_wdata;
                swbsf_pkg::REG_ADDRESS:   r_cfg.address   <= i_cfg_wdata;
                swbsf_pkg::REG_CTRL_ZERO: r_cfg.ctrl_zero <= i_cfg_wdata;
                swbsf_pkg::REG_CTRL_ONE:  r_cfg.ctrl_one  <= i_cfg_wdata;
                swbsf_pkg::REG_RDY_ZERO:  r_cfg.rdy_zero  <= i_cfg_wdata;
                swbsf_pkg::REG_RDY_ONE:   r_cfg.rdy_one   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // item classification and framing state
    swbsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_op     (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .o_push   (w_push),
        .o_job    (w_push_job),
        .i_q_full (w_full)
    );

    // job queue
    swbsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_job   (w_head_job)
    );

    // byte sequencer and output register
    swbsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_head_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_user      (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule
